/* hw/rtl/figa_pkg.sv */
// shared types and constants for the fm initial gain accumulator
package figa_pkg;

  localparam int CELL_W         = 12;
  localparam int GAIN_W         = 32;
  localparam int WEIGHT_W       = 16;
  localparam int DEF_NUM_CELLS  = 4096;
  localparam int DEF_MAX_DEGREE = 64;
  localparam int RECIP_SHIFT    = 24;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 48;

  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

  localparam logic KIND_NET  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_PIN   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CELL_W-1:0]   cell_idx;
    logic                side;
    logic                locked;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [CELL_W-1:0] cell_idx;
    logic [GAIN_W-1:0] gain;
    logic              last;
    logic              too_many;
  } result_t;

endpackage

/* hw/rtl/figa_ram.sv */
// single write port, single read port memory with registered read data
module figa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/figa_cell_wrap.sv */
// two step cell index wrap: reciprocal multiply, then back multiply and subtract
module figa_cell_wrap #(
  parameter int unsigned NUM_CELLS = 4096
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [figa_pkg::CELL_W-1:0] raw,
  output logic [$clog2((NUM_CELLS < (1 << figa_pkg::CELL_W)) ? NUM_CELLS
                       : (1 << figa_pkg::CELL_W))-1:0] cell_idx
);
  import figa_pkg::*;

  localparam bit WRAP = NUM_CELLS < (1 << CELL_W);
  localparam int unsigned GAIN_DEPTH = WRAP ? NUM_CELLS : (1 << CELL_W);
  localparam int AW = $clog2(GAIN_DEPTH);
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W = CELL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    WRAP ? RECIP_W'(((1 << RECIP_SHIFT) + GAIN_DEPTH - 1) / GAIN_DEPTH) : '0;
  localparam logic [CELL_W-1:0] MOD = WRAP ? CELL_W'(GAIN_DEPTH) : '0;

  logic [CELL_W-1:0]   raw_q;
  logic [CELL_W-1:0]   quot_q;
  logic [PROD_W-1:0]   prod;
  logic [2*CELL_W-1:0] back;
  logic [CELL_W-1:0]   rem;
  logic [CELL_W-1:0]   fixed;

  // quotient estimate is exact for 12-bit indexes with a reciprocal scaled by 2^24
  assign prod = PROD_W'(raw) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      raw_q  <= raw;
      quot_q <= prod[RECIP_SHIFT +: CELL_W];
    end
  end

  assign back     = (2*CELL_W)'(quot_q) * (2*CELL_W)'(MOD);
  assign rem      = raw_q - back[CELL_W-1:0];
  assign fixed    = (WRAP && (rem >= MOD)) ? (rem - MOD) : rem;
  assign cell_idx = fixed[AW-1:0];

endmodule

/* hw/rtl/figa_ctrl.sv */
// sequencer: reset clear, pin buffering, reads, clears and net close passes over the pin and gain memories
module figa_ctrl #(
  parameter int GAIN_DEPTH = 4096,
  parameter int MAX_DEGREE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  figa_pkg::item_t                   in_item,
  input  logic [$clog2(GAIN_DEPTH)-1:0]     cell_idx,
  output logic                              pin_we,
  output logic [$clog2(MAX_DEGREE)-1:0]     pin_waddr,
  output logic [$clog2(GAIN_DEPTH)+1:0]     pin_wdata,
  output logic                              pin_re,
  output logic [$clog2(MAX_DEGREE)-1:0]     pin_raddr,
  input  logic [$clog2(GAIN_DEPTH)+1:0]     pin_rdata,
  output logic                              gain_we,
  output logic [$clog2(GAIN_DEPTH)-1:0]     gain_waddr,
  output logic [figa_pkg::GAIN_W-1:0]       gain_wdata,
  output logic                              gain_re,
  output logic [$clog2(GAIN_DEPTH)-1:0]     gain_raddr,
  input  logic [figa_pkg::GAIN_W-1:0]       gain_rdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output figa_pkg::result_t                 out_res
);
  import figa_pkg::*;

  localparam int AW   = $clog2(GAIN_DEPTH);
  localparam int PA_W = $clog2(MAX_DEGREE);
  localparam int PC_W = $clog2(MAX_DEGREE + 1);
  localparam int D_W  = WEIGHT_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RDATA, S_CLOSE, S_UPIN, S_UGAIN
  } state_t;

  typedef enum logic [1:0] {
    UPD_NONE, UPD_TWO, UPD_FREE, UPD_SINGLE
  } upd_mode_t;

  state_t            state;
  item_t             item_q;
  logic [PC_W-1:0]   pin_count;
  logic [PC_W-1:0]   side_cnt [2];
  logic              ovf;
  logic [AW-1:0]     clr_addr;
  logic [PA_W-1:0]   idx;
  upd_mode_t         upd_mode;
  logic              upd_side;
  logic [D_W-1:0]    upd_delta;
  logic              report;
  logic [AW-1:0]     cur_cell;
  logic              cur_side;
  logic              cur_locked;

  logic              out_free;
  logic              load_out;
  logic              last_idx;
  logic              apply;
  logic [GAIN_W:0]   sum;
  logic [GAIN_W-1:0] sat;
  logic [D_W-1:0]    w_ext;

  assign out_free = !out_valid || out_ready;
  assign load_out = out_free && ((state == S_RDATA) || ((state == S_UGAIN) && report));
  assign last_idx = (PC_W'(idx) == (pin_count - 1'b1));
  assign w_ext    = {1'b0, item_q.weight};
  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (upd_mode)
      UPD_TWO:    apply = 1'b1;
      UPD_FREE:   apply = !cur_locked;
      UPD_SINGLE: apply = !cur_locked && (cur_side == upd_side);
      default:    apply = 1'b0;
    endcase
  end

  // saturating add of the signed delta
  assign sum = {gain_rdata[GAIN_W-1], gain_rdata}
             + {{(GAIN_W+1-D_W){upd_delta[D_W-1]}}, upd_delta};
  assign sat = (sum[GAIN_W] != sum[GAIN_W-1]) ? (sum[GAIN_W] ? GAIN_MIN : GAIN_MAX)
                                              : sum[GAIN_W-1:0];

  always_comb begin
    pin_we     = 1'b0;
    pin_waddr  = pin_count[PA_W-1:0];
    pin_wdata  = {item_q.locked, item_q.side, cell_idx};
    pin_re     = 1'b0;
    pin_raddr  = '0;
    gain_we    = 1'b0;
    gain_waddr = cur_cell;
    gain_wdata = sat;
    gain_re    = 1'b0;
    gain_raddr = pin_rdata[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        gain_we    = 1'b1;
        gain_waddr = clr_addr;
        gain_wdata = '0;
      end
      S_EXEC: begin
        unique case (item_q.op)
          OP_PIN: begin
            pin_we = (pin_count < PC_W'(MAX_DEGREE));
          end
          OP_READ: begin
            gain_re    = 1'b1;
            gain_raddr = cell_idx;
          end
          OP_CLEAR: begin
            gain_we    = 1'b1;
            gain_waddr = cell_idx;
            gain_wdata = '0;
          end
          default: begin
          end
        endcase
      end
      S_CLOSE: begin
        pin_re = 1'b1;
      end
      S_UPIN: begin
        gain_re = 1'b1;
      end
      S_UGAIN: begin
        if (!report) begin
          gain_we   = apply;
          pin_re    = 1'b1;
          pin_raddr = last_idx ? '0 : idx + 1'b1;
        end else if (out_free && !last_idx) begin
          pin_re    = 1'b1;
          pin_raddr = idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      pin_count   <= '0;
      side_cnt[0] <= '0;
      side_cnt[1] <= '0;
      ovf         <= 1'b0;
      out_valid   <= 1'b0;
      report      <= 1'b0;
      upd_mode    <= UPD_NONE;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(GAIN_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_q <= in_item;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur_cell <= cell_idx;
          unique case (item_q.op)
            OP_PIN: begin
              if (pin_count < PC_W'(MAX_DEGREE)) begin
                pin_count              <= pin_count + 1'b1;
                side_cnt[item_q.side]  <= side_cnt[item_q.side] + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
              state <= item_q.last ? S_CLOSE : S_IDLE;
            end
            OP_READ: state <= S_RDATA;
            default: state <= S_IDLE;
          endcase
        end
        S_RDATA: begin
          if (out_free) begin
            out_res.kind     <= KIND_READ;
            out_res.cell_idx <= CELL_W'(cur_cell);
            out_res.gain     <= gain_rdata;
            out_res.last     <= 1'b1;
            out_res.too_many <= 1'b0;
            state            <= S_IDLE;
          end
        end
        S_CLOSE: begin
          idx   <= '0;
          state <= S_UPIN;
          // pick the update rule from the pin and side counts
          priority if (pin_count == PC_W'(2)) begin
            upd_mode  <= UPD_TWO;
            upd_delta <= ((side_cnt[0] == PC_W'(2)) || (side_cnt[1] == PC_W'(2)))
                         ? -w_ext : w_ext;
            report    <= 1'b0;
          end else if (pin_count < PC_W'(2)) begin
            upd_mode <= UPD_NONE;
            report   <= 1'b1;
          end else if ((side_cnt[0] == '0) || (side_cnt[1] == '0)) begin
            upd_mode  <= UPD_FREE;
            upd_delta <= -w_ext;
            report    <= 1'b0;
          end else if ((side_cnt[0] == PC_W'(1)) || (side_cnt[1] == PC_W'(1))) begin
            upd_mode  <= UPD_SINGLE;
            upd_side  <= (side_cnt[1] == PC_W'(1));
            upd_delta <= w_ext;
            report    <= 1'b0;
          end else begin
            upd_mode <= UPD_NONE;
            report   <= 1'b1;
          end
        end
        S_UPIN: begin
          cur_cell   <= pin_rdata[AW-1:0];
          cur_side   <= pin_rdata[AW];
          cur_locked <= pin_rdata[AW+1];
          state      <= S_UGAIN;
        end
        S_UGAIN: begin
          if (!report) begin
            state <= S_UPIN;
            if (last_idx) begin
              idx    <= '0;
              report <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (out_free) begin
            out_res.kind     <= KIND_NET;
            out_res.cell_idx <= CELL_W'(cur_cell);
            out_res.gain     <= gain_rdata;
            out_res.last     <= last_idx;
            out_res.too_many <= ovf;
            if (last_idx) begin
              pin_count   <= '0;
              side_cnt[0] <= '0;
              side_cnt[1] <= '0;
              ovf         <= 1'b0;
              report      <= 1'b0;
              state       <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_UPIN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pin count never passes the buffer depth
  assert property (@(posedge clk) disable iff (rst) pin_count <= PC_W'(MAX_DEGREE))
    else $error("pin count beyond buffer depth");

  // every kept pin is counted on exactly one side
  assert property (@(posedge clk) disable iff (rst)
    ((PC_W+1)'(side_cnt[0]) + (PC_W+1)'(side_cnt[1])) == (PC_W+1)'(pin_count))
    else $error("side counts disagree with pin count");

  // gain memory read and write never share a cycle, so no forwarding is needed
  assert property (@(posedge clk) disable iff (rst) !(gain_we && gain_re))
    else $error("gain read and write in the same cycle");

  // a result is only loaded while the output register is free
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_res) && out_valid))
    else $error("pending result overwritten");

endmodule

/* hw/rtl/fm_initial_gain_accumulator_unit.sv */
// top level of the fm initial gain accumulator
//
//  channel  dir  tdata fields (low bit first)              tuser        tlast
//  s_axis   in   cell_index 12, side 1, locked 1,          operation 2  last_pin
//                net_weight 16, zero pad 2
//  m_axis   out  out_cell 12, gain_value 32,               result_kind  last_result
//                too_many_pins 1, zero pad 3
//
// after reset all min(NUM_CELLS, 4096) gain memory entries are cleared one entry
// a cycle with s_axis_tready low; a pin that is not the last, a clear or an idle
// code passes the accept and execute states, and a read also the read data state
// a net closes with one report pass over the buffer when no update rule applies,
// and an update pass before it otherwise: each pin costs one pin memory read and
// one gain memory read in each pass, plus a gain write in the update pass if the
// rule applies; the output register holds a result until taken, a stalled m_axis
// holds the report pass; s_axis takes the next request while a result waits
module fm_initial_gain_accumulator_unit #(
  parameter int unsigned NUM_CELLS  = figa_pkg::DEF_NUM_CELLS,
  parameter int          MAX_DEGREE = figa_pkg::DEF_MAX_DEGREE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cell_index [11:0], side [12], locked [13], net_weight [29:14], zero [31:30]
  input  logic [figa_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_cell [11:0], gain_value [43:12], too_many_pins [44], zero [47:45]
  output logic [figa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind [0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import figa_pkg::*;

  // only indexes that fit in 12 bits can ever reach the gain memory
  localparam int GAIN_DEPTH = (NUM_CELLS < (1 << CELL_W)) ? int'(NUM_CELLS) : (1 << CELL_W);
  localparam int AW         = $clog2(GAIN_DEPTH);
  localparam int PA_W       = $clog2(MAX_DEGREE);
  localparam int PIN_W      = AW + 2;

  item_t             item;
  result_t           res;
  logic [AW-1:0]     cell_idx;

  logic              pin_we;
  logic [PA_W-1:0]   pin_waddr;
  logic [PIN_W-1:0]  pin_wdata;
  logic              pin_re;
  logic [PA_W-1:0]   pin_raddr;
  logic [PIN_W-1:0]  pin_rdata;
  logic              gain_we;
  logic [AW-1:0]     gain_waddr;
  logic [GAIN_W-1:0] gain_wdata;
  logic              gain_re;
  logic [AW-1:0]     gain_raddr;
  logic [GAIN_W-1:0] gain_rdata;

  // unpack the request
  assign item.op       = op_t'(s_axis_tuser);
  assign item.cell_idx = s_axis_tdata[CELL_W-1:0];
  assign item.side     = s_axis_tdata[CELL_W];
  assign item.locked   = s_axis_tdata[CELL_W+1];
  assign item.weight   = s_axis_tdata[CELL_W+2 +: WEIGHT_W];
  assign item.last     = s_axis_tlast;

  // index wrap starts on the accept edge, ready in the cycle after
  figa_cell_wrap #(
    .NUM_CELLS (NUM_CELLS)
  ) u_wrap (
    .clk      (clk),
    .en       (s_axis_tvalid && s_axis_tready),
    .raw      (item.cell_idx),
    .cell_idx (cell_idx)
  );

  // buffered pins of the open net: {locked, side, cell}
  figa_ram #(
    .WIDTH (PIN_W),
    .DEPTH (MAX_DEGREE)
  ) u_pin_ram (
    .clk   (clk),
    .we    (pin_we),
    .waddr (pin_waddr),
    .wdata (pin_wdata),
    .re    (pin_re),
    .raddr (pin_raddr),
    .rdata (pin_rdata)
  );

  // per cell gains
  figa_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (GAIN_DEPTH)
  ) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (gain_waddr),
    .wdata (gain_wdata),
    .re    (gain_re),
    .raddr (gain_raddr),
    .rdata (gain_rdata)
  );

  figa_ctrl #(
    .GAIN_DEPTH (GAIN_DEPTH),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (item),
    .cell_idx   (cell_idx),
    .pin_we     (pin_we),
    .pin_waddr  (pin_waddr),
    .pin_wdata  (pin_wdata),
    .pin_re     (pin_re),
    .pin_raddr  (pin_raddr),
    .pin_rdata  (pin_rdata),
    .gain_we    (gain_we),
    .gain_waddr (gain_waddr),
    .gain_wdata (gain_wdata),
    .gain_re    (gain_re),
    .gain_raddr (gain_raddr),
    .gain_rdata (gain_rdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res)
  );

  // pack the result
  assign m_axis_tdata = {(OUT_DATA_W - CELL_W - GAIN_W - 1)'(0), res.too_many, res.gain,
                         res.cell_idx};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
